/* hdl/sip_pkg.sv */
// ============================================================================
// sip_pkg
// Shared types, constants and round functions for the SipHash-2-4 engine.
// ============================================================================
package sip_pkg;

    // Initialization constants of the four lanes
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    // Constant folded into v2 before the finalization rounds
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    // Bytes in one message word
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // Configuration register indexes (one 64-bit register per 8-byte slot)
    typedef enum logic
    {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_idx_t;

    // The four 64-bit lanes of the hash state
    typedef struct packed
    {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } lanes_t;

    // One SipRound: adds, fixed rotates and XORs
    function automatic lanes_t sip_round(input lanes_t v);
        lanes_t r;
        r = v;
        r.v0 = r.v0 + r.v1;
        r.v1 = {r.v1[50:0], r.v1[63:51]};
        r.v1 = r.v1 ^ r.v0;
        r.v0 = {r.v0[31:0], r.v0[63:32]};
        r.v2 = r.v2 + r.v3;
        r.v3 = {r.v3[47:0], r.v3[63:48]};
        r.v3 = r.v3 ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = {r.v3[42:0], r.v3[63:43]};
        r.v3 = r.v3 ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = {r.v1[46:0], r.v1[63:47]};
        r.v1 = r.v1 ^ r.v2;
        r.v2 = {r.v2[31:0], r.v2[63:32]};
        return r;
    endfunction

    // Two back-to-back SipRounds
    function automatic lanes_t sip_two_rounds(input lanes_t v);
        return sip_round(sip_round(v));
    endfunction

    // Fold one 64-bit block into the lanes with two rounds
    function automatic lanes_t sip_compress(input lanes_t v, input logic [63:0] blk);
        lanes_t r;
        r = v;
        r.v3 = r.v3 ^ blk;
        r = sip_two_rounds(r);
        r.v0 = r.v0 ^ blk;
        return r;
    endfunction

endpackage

/* hdl/sip_in_if.sv */
// ============================================================================
// sip_in_if
// Message word channel: valid/ready with word, byte count and last flag.
// ============================================================================
interface sip_in_if;

    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source
    (
        output valid,
        output message_word,
        output byte_count,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  message_word,
        input  byte_count,
        input  last,
        output ready
    );

endinterface

/* hdl/sip_out_if.sv */
// ============================================================================
// sip_out_if
// Hash result channel: valid/ready with the 64-bit hash.
// ============================================================================
interface sip_out_if;

    logic        valid;
    logic        ready;
    logic [63:0] hash;

    modport source
    (
        output valid,
        output hash,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  hash,
        output ready
    );

endinterface

/* hdl/siphash_2_4_keyed_hash.sv */
// ============================================================================
// siphash_2_4_keyed_hash
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words.
// ============================================================================
// The engine takes one message word per clock cycle unless finalization is
// backed up: the lane registers are updated by two SipRounds in the cycle the
// word transfers, which is the loop that sets the rate. A last word leaves the
// lane loop and moves into a three-stage finalization pipeline (tail block
// compression, then two pairs of rounds), so the next message may start in
// the very next cycle. The hash passes the f1, f2, f3 and hash registers and
// is held on the result channel until taken; the pipeline keeps moving behind
// it until its stages fill. The key registers sit at byte addresses 0 and 8 of
// the APB port (paddr[3] selects) and are sampled when a message starts.
// ============================================================================
module siphash_2_4_keyed_hash
(
    input  logic         clk,
    input  logic         rst_n,

    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,

    // Streams
    sip_in_if.sink       msg,
    sip_out_if.source    res
);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    logic [63:0]            key_low_reg,  key_low_next;
    logic [63:0]            key_high_reg, key_high_next;

    sip_pkg::lanes_t        lanes_reg,    lanes_next;
    logic [7:0]             length_reg,   length_next;
    logic                   in_msg_reg,   in_msg_next;

    sip_pkg::lanes_t        f1_lanes_reg, f1_lanes_next;
    logic [63:0]            f1_tail_reg,  f1_tail_next;
    logic                   f1_vld_reg,   f1_vld_next;
    sip_pkg::lanes_t        f2_lanes_reg, f2_lanes_next;
    logic                   f2_vld_reg,   f2_vld_next;
    sip_pkg::lanes_t        f3_lanes_reg, f3_lanes_next;
    logic                   f3_vld_reg,   f3_vld_next;
    logic [63:0]            hash_reg,     hash_next;
    logic                   out_vld_reg,  out_vld_next;

    logic                   cfg_wr;
    sip_pkg::reg_idx_t      cfg_idx;
    logic                   msg_xfer;
    logic                   f2_ld;
    logic                   f3_ld;
    logic                   out_ld;

    sip_pkg::lanes_t        base_lanes;
    sip_pkg::lanes_t        word_lanes;
    sip_pkg::lanes_t        sel_lanes;
    sip_pkg::lanes_t        f2_calc;
    sip_pkg::lanes_t        f3_calc;
    sip_pkg::lanes_t        fin_calc;
    logic [7:0]             base_len;
    logic [7:0]             len_add;
    logic [7:0]             len_sum;
    logic [3:0]             cnt_sat;
    logic                   full_word;
    logic [55:0]            tail_bytes;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = sip_pkg::reg_idx_t'(paddr[3]);

    always_comb
    begin
        unique case (cfg_idx)
            sip_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            sip_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            default:               prdata = key_low_reg;
        endcase
    end

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                sip_pkg::REG_KEY_LOW:  key_low_next  = pwdata;
                sip_pkg::REG_KEY_HIGH: key_high_next = pwdata;
                default:               key_low_next  = key_low_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline handshake: each stage advances when the one ahead makes room
    // ------------------------------------------------------------------------
    assign out_ld    = f3_vld_reg && (!out_vld_reg || res.ready);
    assign f3_ld     = f2_vld_reg && (!f3_vld_reg || out_ld);
    assign f2_ld     = f1_vld_reg && (!f2_vld_reg || f3_ld);
    assign msg.ready = !f1_vld_reg || f2_ld;
    assign msg_xfer  = msg.valid && msg.ready;

    // ------------------------------------------------------------------------
    // Word stage: start lanes, compress a full word, build the tail block
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (in_msg_reg)
        begin
            base_lanes = lanes_reg;
            base_len   = length_reg;
        end
        else
        begin
            base_lanes.v0 = sip_pkg::SIP_C0 ^ key_low_reg;
            base_lanes.v1 = sip_pkg::SIP_C1 ^ key_high_reg;
            base_lanes.v2 = sip_pkg::SIP_C2 ^ key_low_reg;
            base_lanes.v3 = sip_pkg::SIP_C3 ^ key_high_reg;
            base_len      = 8'd0;
        end
    end

    // Saturate the byte count; non-last words always count as full
    assign cnt_sat    = (msg.byte_count > sip_pkg::WORD_BYTES) ?
                        sip_pkg::WORD_BYTES : msg.byte_count;
    assign full_word  = !msg.last || (cnt_sat == sip_pkg::WORD_BYTES);
    assign word_lanes = sip_pkg::sip_compress(base_lanes, msg.message_word);
    assign sel_lanes  = full_word ? word_lanes : base_lanes;
    assign len_add    = full_word ? {4'd0, sip_pkg::WORD_BYTES} : {4'd0, cnt_sat};
    assign len_sum    = base_len + len_add;

    // Keep the leftover bytes of a short last word, drop the rest
    always_comb
    begin
        for (int b = 0; b < 7; b++)
        begin
            tail_bytes[8*b +: 8] = (!full_word && (4'(b) < cnt_sat)) ?
                                   msg.message_word[8*b +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        lanes_next    = lanes_reg;
        length_next   = length_reg;
        in_msg_next   = in_msg_reg;
        f1_lanes_next = f1_lanes_reg;
        f1_tail_next  = f1_tail_reg;
        f1_vld_next   = f2_ld ? 1'b0 : f1_vld_reg;
        if (msg_xfer)
        begin
            if (msg.last)
            begin
                in_msg_next   = 1'b0;
                f1_lanes_next = sel_lanes;
                f1_tail_next  = {len_sum, tail_bytes};
                f1_vld_next   = 1'b1;
            end
            else
            begin
                in_msg_next = 1'b1;
                lanes_next  = word_lanes;
                length_next = len_sum;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Finalization: tail compression, then two pairs of rounds, then fold
    // ------------------------------------------------------------------------
    always_comb
    begin
        f2_calc    = sip_pkg::sip_compress(f1_lanes_reg, f1_tail_reg);
        f2_calc.v2 = f2_calc.v2 ^ sip_pkg::FINAL_XOR;
    end

    assign f3_calc  = sip_pkg::sip_two_rounds(f2_lanes_reg);
    assign fin_calc = sip_pkg::sip_two_rounds(f3_lanes_reg);

    always_comb
    begin
        f2_lanes_next = f2_ld  ? f2_calc  : f2_lanes_reg;
        f3_lanes_next = f3_ld  ? f3_calc  : f3_lanes_reg;
        hash_next     = out_ld ? (fin_calc.v0 ^ fin_calc.v1 ^ fin_calc.v2 ^ fin_calc.v3)
                               : hash_reg;
        f2_vld_next   = f2_ld  ? 1'b1 : (f3_ld ? 1'b0 : f2_vld_reg);
        f3_vld_next   = f3_ld  ? 1'b1 : (out_ld ? 1'b0 : f3_vld_reg);
        out_vld_next  = out_ld ? 1'b1 : (res.ready ? 1'b0 : out_vld_reg);
    end

    assign res.valid = out_vld_reg;
    assign res.hash  = hash_reg;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            in_msg_reg   <= 1'b0;
            length_reg   <= '0;
            f1_vld_reg   <= 1'b0;
            f2_vld_reg   <= 1'b0;
            f3_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            in_msg_reg   <= in_msg_next;
            length_reg   <= length_next;
            f1_vld_reg   <= f1_vld_next;
            f2_vld_reg   <= f2_vld_next;
            f3_vld_reg   <= f3_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Hold lane and result payloads; no reset needed
    always_ff @(posedge clk)
    begin
        lanes_reg    <= lanes_next;
        f1_lanes_reg <= f1_lanes_next;
        f1_tail_reg  <= f1_tail_next;
        f2_lanes_reg <= f2_lanes_next;
        f3_lanes_reg <= f3_lanes_next;
        hash_reg     <= hash_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A last word enters finalization and closes the message
    a_last_enters_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_xfer && msg.last) |=> (f1_vld_reg && !in_msg_reg))
        else $error("last word did not enter finalization");

    // A full word keeps the message open
    a_word_opens_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_xfer && !msg.last) |=> in_msg_reg)
        else $error("message not open after a full word");

    // A stalled result keeps the stage behind it occupied
    a_stall_holds_f3: assert property (@(posedge clk) disable iff (!rst_n)
        (f3_vld_reg && out_vld_reg && !res.ready) |=> f3_vld_reg)
        else $error("finalization stage lost during output stall");

    // The last stage never drops a result while the output is full
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res.ready) |=> (out_vld_reg && $stable(hash_reg)))
        else $error("pending hash overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the keyed SipHash-2-4 engine. A lane-level model
// predicts the hash of every message as its last word transfers, and each
// hash transfer is compared in order. Covers reset keys, published test
// vectors, every byte count, key rewrites mid-message, a long output stall
// and several key settings under random message traffic.
// ============================================================================
module testbench;

    // Lane seeds, folded with the key at the start of each message
    localparam logic [63:0] SEED_V0 = 64'h736f6d6570736575;
    localparam logic [63:0] SEED_V1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SEED_V2 = 64'h6c7967656e657261;
    localparam logic [63:0] SEED_V3 = 64'h7465646279746573;
    localparam logic [63:0] TAIL_FLIP = 64'h00000000000000ff;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_WORDS  = 300;

    typedef struct packed
    {
        logic [63:0] l0;
        logic [63:0] l1;
        logic [63:0] l2;
        logic [63:0] l3;
    } lane_set_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    sip_in_if  msg_if ();
    sip_out_if res_if ();

    // Hash model state
    logic [63:0] key_lo_model = '0;
    logic [63:0] key_hi_model = '0;
    lane_set_t   lanes = '0;
    logic [7:0]  msg_len = '0;
    logic        msg_open = 1'b0;
    logic [63:0] hash_expected_q [$];

    int   mismatch_count = 0;
    int   words_sent = 0;
    logic src_gaps_on = 1'b1;
    logic sink_gaps_on = 1'b1;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;

    siphash_2_4_keyed_hash dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .msg     (msg_if),
        .res     (res_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic lane_set_t sip_mix(input lane_set_t v);
        lane_set_t r;
        r = v;
        r.l0 = r.l0 + r.l1;
        r.l1 = rotl(r.l1, 13) ^ r.l0;
        r.l0 = rotl(r.l0, 32);
        r.l2 = r.l2 + r.l3;
        r.l3 = rotl(r.l3, 16) ^ r.l2;
        r.l0 = r.l0 + r.l3;
        r.l3 = rotl(r.l3, 21) ^ r.l0;
        r.l2 = r.l2 + r.l1;
        r.l1 = rotl(r.l1, 17) ^ r.l2;
        r.l2 = rotl(r.l2, 32);
        return r;
    endfunction

    function automatic lane_set_t absorb_block(input lane_set_t v, input logic [63:0] blk);
        lane_set_t r;
        r = v;
        r.l3 = r.l3 ^ blk;
        r = sip_mix(sip_mix(r));
        r.l0 = r.l0 ^ blk;
        return r;
    endfunction

    // Advance the model by one accepted word; queue the hash on a last word
    task automatic predict_hash(input logic [63:0] word, input logic [3:0] count,
                                input logic is_last);
        logic [3:0]  n;
        logic [63:0] tail;
        if (!msg_open)
        begin
            lanes.l0 = SEED_V0 ^ key_lo_model;
            lanes.l1 = SEED_V1 ^ key_hi_model;
            lanes.l2 = SEED_V2 ^ key_lo_model;
            lanes.l3 = SEED_V3 ^ key_hi_model;
            msg_len  = '0;
            msg_open = 1'b1;
        end
        if (!is_last)
        begin
            lanes   = absorb_block(lanes, word);
            msg_len = msg_len + 8'd8;
        end
        else
        begin
            // Saturate oversized counts to a full word
            n = (count > 4'd8) ? 4'd8 : count;
            if (n == 4'd8)
            begin
                lanes   = absorb_block(lanes, word);
                msg_len = msg_len + 8'd8;
                tail    = '0;
            end
            else
            begin
                tail    = word & ((64'd1 << (8 * n)) - 64'd1);
                msg_len = msg_len + 8'(n);
            end
            tail[63:56] = msg_len;
            lanes = absorb_block(lanes, tail);
            lanes.l2 = lanes.l2 ^ TAIL_FLIP;
            repeat (4) lanes = sip_mix(lanes);
            hash_expected_q.push_back(lanes.l0 ^ lanes.l1 ^ lanes.l2 ^ lanes.l3);
            msg_open = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Offer one word, hold it until it transfers; valid stays high on return
    task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                             input logic is_last);
        while (src_gaps_on && $urandom_range(99) < 18)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.message_word <= word;
        msg_if.byte_count   <= count;
        msg_if.last         <= is_last;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        predict_hash(word, count, is_last);
        words_sent++;
    endtask

    // Drop valid, wait for all hashes, then let the pipeline settle
    task automatic drain_results(input int extra_cycles);
        msg_if.valid <= 1'b0;
        while (hash_expected_q.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    // Setup and access cycle of one register write; psel stays high on return
    task automatic write_key(input sip_pkg::reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == sip_pkg::REG_KEY_LOW)
            key_lo_model = value;
        else
            key_hi_model = value;
    endtask

    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
        write_key(sip_pkg::REG_KEY_LOW, lo);
        write_key(sip_pkg::REG_KEY_HIGH, hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_message();
        int n_full;
        int pick;
        logic [3:0] count;
        // Mostly short messages; a few long enough to wrap the length byte
        n_full = ($urandom_range(99) < 8) ? $urandom_range(40, 30) : $urandom_range(4, 0);
        for (int i = 0; i < n_full; i++)
            send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
        pick = $urandom_range(99);
        if (pick < 60)
            count = 4'($urandom_range(8, 0));
        else if (pick < 80)
            count = 4'd8;
        else
            count = 4'($urandom_range(15, 9));
        send_word(rand_word(), count, 1'b1);
    endtask

    task automatic check_model(input logic [63:0] want);
        if (hash_expected_q[$] !== want)
        begin
            $display("%0t: model vector: expected %h, actual %h", $time, want,
                     hash_expected_q[$]);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and output stall control
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (res_if.valid && res_if.ready)
        begin
            if (hash_expected_q.size() == 0)
            begin
                $display("%0t: unexpected hash transfer: expected none, actual %h",
                         $time, res_if.hash);
                mismatch_count++;
            end
            else
            begin
                want = hash_expected_q.pop_front();
                if (res_if.hash !== want)
                begin
                    $display("%0t: hash mismatch: expected %h, actual %h", $time, want,
                             res_if.hash);
                    mismatch_count++;
                end
            end
        end
        res_if.ready <= rst_n && hold_left == 0 &&
                        !(sink_gaps_on && $urandom_range(99) < 18);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_key();
        send_word(rand_word(), 4'd0, 1'b1);
        send_word('1, 4'd8, 1'b1);
    endtask

    task automatic test_known_answer();
        drain_results(SETTLE_CYCLES);
        load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        // Empty message; junk in the word must be masked off
        send_word('1, 4'd0, 1'b1);
        check_model(64'h726fdb47dd0e0e31);
        // 15-byte message; count on the first word is ignored
        send_word(64'h0706050403020100, 4'd0, 1'b0);
        send_word(64'hab0e0d0c0b0a0908, 4'd7, 1'b1);
        check_model(64'ha129ca6149be45e5);
    endtask

    task automatic test_byte_counts();
        for (int c = 0; c < 16; c++)
            send_word((c % 2 == 1) ? '1 : rand_word(), 4'(c), 1'b1);
        // Full last word after a full word, and an all-zero word
        send_word(rand_word(), 4'd15, 1'b0);
        send_word(rand_word(), 4'd8, 1'b1);
        send_word('0, 4'd8, 1'b1);
    endtask

    task automatic test_key_mid_message();
        send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
        send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
        // New key must not reach the open message, only the next one
        drain_results(SETTLE_CYCLES);
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        send_word(rand_word(), 4'd5, 1'b1);
        send_word(rand_word(), 4'd3, 1'b1);
    endtask

    task automatic test_output_stall();
        drain_results(SETTLE_CYCLES);
        src_gaps_on = 1'b0;
        sink_gaps_on <= 1'b0;
        hold_req <= hold_req + 1;
        // Keep offering single-word messages so the block backs up
        for (int i = 0; i < 40; i++)
            send_word(rand_word(), 4'($urandom_range(8)), 1'b1);
        src_gaps_on = 1'b1;
        sink_gaps_on <= 1'b1;
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int p = 0; p < 5; p++)
        begin
            drain_results(SETTLE_CYCLES);
            case (p)
                0: load_key('0, '0);
                1: load_key('1, '1);
                3: load_key('0, '1);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            // One phase runs back to back on both sides
            src_gaps_on = (p != 2);
            sink_gaps_on <= (p != 2);
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
                send_random_message();
        end
        src_gaps_on = 1'b1;
        sink_gaps_on <= 1'b1;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        msg_if.valid        = 1'b0;
        msg_if.message_word = '0;
        msg_if.byte_count   = '0;
        msg_if.last         = 1'b0;
        res_if.ready        = 1'b0;

        // Hold reset, then release at an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_known_answer();
        test_byte_counts();
        test_key_mid_message();
        test_output_stall();
        test_random_traffic();

        drain_results(TAIL_CYCLES);
        if (mismatch_count == 0)
            $display("siphash_2_4_keyed_hash test passed");
        else
            $display("siphash_2_4_keyed_hash test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("siphash_2_4_keyed_hash test failed");
        $finish;
    end

endmodule
